FILE: hdl/cfs_pkg.sv
// cfs_pkg: shared types and constants for the cooling fan supervisor
// command codes, read status codes, option and diagnostic bit positions
// no dependencies
package cfs_pkg;

   typedef enum logic [2:0] {
      CMD_TICK        = 3'd0,
      CMD_CRANK       = 3'd1,
      CMD_IGNITION    = 3'd2,
      CMD_EMERGENCY   = 3'd3,
      CMD_ACTIVATE    = 3'd4,
      CMD_FORCE_RESET = 3'd5,
      CMD_FORCE_SET   = 3'd6
   } cmd_type;

   // register indexes on the csr port
   localparam logic [2:0] REG_CRANK_TIMEOUT = 3'd0;
   localparam logic [2:0] REG_MIN_RPM       = 3'd1;
   localparam logic [2:0] REG_DELAY_ON      = 3'd2;
   localparam logic [2:0] REG_DELAY_OFF     = 3'd3;
   localparam logic [2:0] REG_FB_ON_THRESH  = 3'd4;
   localparam logic [2:0] REG_FB_OFF_THRESH = 3'd5;
   localparam logic [2:0] REG_OPTIONS       = 3'd6;
   localparam logic [2:0] REG_CRANK_MODE    = 3'd7;

   // read status codes
   localparam logic [1:0] RD_OK        = 2'd0;
   localparam logic [1:0] RD_NOT_READY = 2'd1;

   // crank validity codes
   localparam logic [1:0] CRANK_NONE = 2'd0;
   localparam logic [1:0] CRANK_SYNC = 2'd2;

   // option_flags bit positions
   localparam int OPT_FORCE_INV   = 0;
   localparam int OPT_ALLOW_FORCE = 1;
   localparam int OPT_FB_INV      = 2;
   localparam int OPT_DRIVE       = 3;
   localparam int OPT_FB          = 4;
   localparam int OPT_FORCE       = 5;
   localparam int OPT_ANALOG      = 6;
   localparam int OPT_ENABLED     = 7;

   // diagnostic bit positions
   localparam int DG_DRIVE    = 0;
   localparam int DG_FORCE    = 1;
   localparam int DG_FB       = 2;
   localparam int DG_STUCKOFF = 3;
   localparam int DG_STUCKON  = 4;

   typedef struct packed {
      logic        fan_state;
      logic        drive_prev;
      logic        crank_run_accept;
      logic [31:0] crank_last_time;
      logic [13:0] crank_speed;
      logic        crank_seen;
      logic        crank_triggered;
      logic        ignition_state;
      logic        emergency_state;
      logic        activate_state;
      logic        override_engaged;
      logic        override_value;
      logic [31:0] switch_time;
      logic        check_valid;
      logic [11:0] feedback_level;
      logic [4:0]  diag;
   } state_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] time_now;
      logic        flag_value;
      logic [1:0]  crank_validity;
      logic [13:0] crank_rpm;
      logic        force_pin_level;
      logic [1:0]  force_read_status;
      logic [11:0] feedback_sample;
      logic [1:0]  feedback_read_status;
      logic        drive_write_fault;
   } item_type;

endpackage

FILE: hdl/cooling_fan_supervisor.sv
// cooling_fan_supervisor: engine cooling fan on/off supervisor, top level
// holds the input stage, the state update logic and the result register
// depends on cfs_pkg
//
// usage:
//  req channel: one beat per event or tick; req_tuser carries the command,
//  req_tdata the time stamp, event arguments and the pin samples of a tick.
//  rsp channel: exactly one beat per req beat, in order, showing the fan
//  state, the drive level, the check flag, the sticky diagnostics and the
//  crank detected flag as they stand after that item.
//  csr port: csr_we writes csr_wdata into register csr_index at once;
//  the user must write it only while no item is in flight; the block does not enforce it.
//  throughput: one item per cycle unless rsp_tready stalls; each item passes the input register and
//  the compare-and-update logic (the crank run-on compare feeds the fan state,
//  which picks the settle delay for a second 32-bit subtract and compare, the
//  longest path) and lands in the result register.
//  stall: while rsp_tready is low, the result register holds and one more
//  item waits in the input register; req_tready drops only when both are
//  full and the result is not being taken.
//  reset: synchronous, clears the configuration registers, the valid flags, state and
//  diagnostics to zero, which leaves the block disabled until option bit 7 is written.
module cooling_fan_supervisor
   import cfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[2:0]
   input  logic [2:0]  req_tuser,
   // time_now[31:0], flag_value[32], crank_validity[34:33], crank_rpm[48:35],
   // force_pin_level[49], force_read_status[51:50], feedback_sample[63:52],
   // feedback_read_status[65:64], drive_write_fault[66], zero[71:67]
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // fan_on[0], drive_level[1], feedback_checked[2], drive_error[3],
   // force_input_error[4], feedback_input_error[5], stuck_off_error[6],
   // stuck_on_error[7], crank_detected[8], zero[15:9]
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // configuration registers
   logic [31:0] crank_timeout_ff, delay_on_ff, delay_off_ff;
   logic [13:0] min_rpm_ff;
   logic [11:0] fb_on_thresh_ff, fb_off_thresh_ff;
   logic [7:0]  options_ff;
   logic        crank_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         crank_timeout_ff <= '0;
         min_rpm_ff       <= '0;
         delay_on_ff      <= '0;
         delay_off_ff     <= '0;
         fb_on_thresh_ff  <= '0;
         fb_off_thresh_ff <= '0;
         options_ff       <= '0;
         crank_mode_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_CRANK_TIMEOUT: crank_timeout_ff <= csr_wdata;
            REG_MIN_RPM:       min_rpm_ff       <= csr_wdata[13:0];
            REG_DELAY_ON:      delay_on_ff      <= csr_wdata;
            REG_DELAY_OFF:     delay_off_ff     <= csr_wdata;
            REG_FB_ON_THRESH:  fb_on_thresh_ff  <= csr_wdata[11:0];
            REG_FB_OFF_THRESH: fb_off_thresh_ff <= csr_wdata[11:0];
            REG_OPTIONS:       options_ff       <= csr_wdata[7:0];
            REG_CRANK_MODE:    crank_mode_ff    <= csr_wdata[0];
            default:           crank_mode_ff    <= crank_mode_ff;
         endcase
      end
   end

   // input stage
   logic     s1_valid_ff;
   item_type s1_item_ff, s1_item_in;
   logic     advance;
   logic     rsp_valid_ff;
   logic [8:0] rsp_data_ff, rsp_data_in;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_comb begin
      s1_item_in.command              = req_tuser;
      s1_item_in.time_now             = req_tdata[31:0];
      s1_item_in.flag_value           = req_tdata[32];
      s1_item_in.crank_validity       = req_tdata[34:33];
      s1_item_in.crank_rpm            = req_tdata[48:35];
      s1_item_in.force_pin_level      = req_tdata[49];
      s1_item_in.force_read_status    = req_tdata[51:50];
      s1_item_in.feedback_sample      = req_tdata[63:52];
      s1_item_in.feedback_read_status = req_tdata[65:64];
      s1_item_in.drive_write_fault    = req_tdata[66];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_item_ff <= s1_item_in;
      end
   end

   // state update
   state_type state_ff, state_in;
   logic [31:0] settle;
   logic [31:0] crank_age, switch_age;
   logic        force_lvl, fb_lvl, enabled;
   item_type    it;

   assign it      = s1_item_ff;
   assign enabled = options_ff[OPT_ENABLED];

   always_comb begin
      state_in   = state_ff;
      settle     = '0;
      crank_age  = it.time_now - state_ff.crank_last_time;
      switch_age = '0;
      force_lvl  = it.force_pin_level ^ options_ff[OPT_FORCE_INV];
      fb_lvl     = (it.feedback_sample != '0) ^ options_ff[OPT_FB_INV];
      if (enabled) begin
         unique case (cmd_type'(it.command))
            CMD_TICK: begin
               if (state_in.emergency_state && state_in.ignition_state) begin
                  state_in.fan_state = 1'b1;
               end
               if (state_in.activate_state) begin
                  if (state_in.crank_triggered && state_in.ignition_state) begin
                     state_in.fan_state        = 1'b1;
                     state_in.crank_run_accept = 1'b1;
                  end else if (state_in.crank_run_accept) begin
                     if (crank_age >= crank_timeout_ff) begin
                        state_in.fan_state        = 1'b0;
                        state_in.crank_run_accept = 1'b0;
                     end else begin
                        state_in.fan_state = 1'b1;
                     end
                  end
               end
               if (options_ff[OPT_FORCE]) begin
                  if (it.force_read_status == RD_OK) begin
                     if (force_lvl && options_ff[OPT_ALLOW_FORCE]) begin
                        state_in.fan_state = 1'b1;
                     end
                  end else if (it.force_read_status != RD_NOT_READY) begin
                     state_in.diag[DG_FORCE] = 1'b1;
                  end
               end
               // low rpm cutoff
               if (state_in.ignition_state && state_in.crank_seen &&
                   state_in.crank_speed != '0 && state_in.crank_speed < min_rpm_ff) begin
                  state_in.fan_state = 1'b0;
               end
               if (state_in.override_engaged) begin
                  state_in.fan_state = state_in.override_value;
               end
               // drive change restarts the settle delay even on a write fault
               if (state_in.drive_prev != state_in.fan_state) begin
                  if (options_ff[OPT_DRIVE] && it.drive_write_fault) begin
                     state_in.diag[DG_DRIVE] = 1'b1;
                  end else begin
                     state_in.drive_prev = state_in.fan_state;
                  end
                  state_in.switch_time = it.time_now;
                  state_in.check_valid = 1'b0;
               end
               settle     = state_in.fan_state ? delay_on_ff : delay_off_ff;
               switch_age = it.time_now - state_in.switch_time;
               if (options_ff[OPT_FB]) begin
                  if (!state_in.check_valid) begin
                     if (switch_age >= settle) begin
                        state_in.check_valid = 1'b1;
                     end
                  end else begin
                     if (it.feedback_read_status == RD_OK) begin
                        state_in.feedback_level = it.feedback_sample;
                     end else if (it.feedback_read_status != RD_NOT_READY) begin
                        state_in.diag[DG_FB] = 1'b1;
                     end
                     if (options_ff[OPT_ANALOG]) begin
                        if (state_in.fan_state &&
                            state_in.feedback_level < fb_on_thresh_ff) begin
                           state_in.diag[DG_STUCKOFF] = 1'b1;
                        end else if (!state_in.fan_state &&
                                     state_in.feedback_level > fb_off_thresh_ff) begin
                           state_in.diag[DG_STUCKON] = 1'b1;
                        end
                     end else begin
                        if (state_in.fan_state && !fb_lvl) begin
                           state_in.diag[DG_STUCKOFF] = 1'b1;
                        end else if (!state_in.fan_state && fb_lvl) begin
                           state_in.diag[DG_STUCKON] = 1'b1;
                        end
                     end
                  end
               end
            end
            CMD_CRANK: begin
               if (it.crank_validity == CRANK_NONE) begin
                  state_in.crank_triggered = 1'b0;
                  state_in.crank_seen      = 1'b0;
                  state_in.crank_speed     = '0;
               end else begin
                  state_in.crank_seen = 1'b1;
                  // validity 3 counts as synchronized
                  if (!crank_mode_ff || it.crank_validity >= CRANK_SYNC) begin
                     state_in.crank_triggered = 1'b1;
                  end
                  if (state_in.crank_triggered) begin
                     state_in.crank_last_time = it.time_now;
                  end
                  state_in.crank_speed = it.crank_rpm;
               end
            end
            CMD_IGNITION:  state_in.ignition_state  = it.flag_value;
            CMD_EMERGENCY: state_in.emergency_state = it.flag_value;
            CMD_ACTIVATE:  state_in.activate_state  = it.flag_value;
            CMD_FORCE_RESET: begin
               state_in.override_engaged = 1'b0;
               state_in.override_value   = 1'b0;
            end
            CMD_FORCE_SET: begin
               state_in.override_engaged = 1'b1;
               state_in.override_value   = it.flag_value;
            end
            default: state_in = state_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   assign rsp_data_in = {state_in.crank_seen,
                         state_in.diag[DG_STUCKON],
                         state_in.diag[DG_STUCKOFF],
                         state_in.diag[DG_FB],
                         state_in.diag[DG_FORCE],
                         state_in.diag[DG_DRIVE],
                         state_in.check_valid,
                         state_in.drive_prev,
                         state_in.fan_state};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_data_ff};

   // diagnostics are sticky
   a_diag_sticky: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((state_ff.diag & $past(state_ff.diag)) == $past(state_ff.diag)))
      else $error("sticky diagnostic bit cleared");

   // state moves only when an item passes into the result register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without an item");

   // a waiting beat in the input stage is never dropped
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_item_ff)))
      else $error("input stage beat lost");

   // drive level only ever follows the commanded state
   a_drive_follow: assert property (@(posedge clock) disable iff (reset)
      !$stable(state_ff.drive_prev) |-> (state_ff.drive_prev == state_ff.fan_state))
      else $error("drive level moved away from fan state");

endmodule

FILE: tb/tb_cooling_fan_supervisor.sv
// tb_cooling_fan_supervisor: self-checking bench for the cooling fan supervisor
// stream driver and monitor around an item-level prediction of the fan logic
// depends on cfs_pkg and cooling_fan_supervisor
`timescale 1ns / 100ps

module tb_cooling_fan_supervisor
   import cfs_pkg::*;
();

   localparam int TIMEOUT_NS  = 2000000;
   localparam int DRAIN_TAIL  = 8;
   localparam int MAX_REPORTS = 60;

   localparam logic [2:0] CMD_UNKNOWN    = 3'd7;
   localparam logic [1:0] RD_ERROR       = 2'd2;
   localparam logic [1:0] RD_ODD         = 2'd3;
   localparam logic [1:0] CRANK_DETECTED = 2'd1;
   localparam logic [1:0] CRANK_ODD      = 2'd3;

   typedef struct packed {
      logic [31:0] crank_timeout;
      logic [13:0] min_rpm;
      logic [31:0] delay_on;
      logic [31:0] delay_off;
      logic [11:0] on_thresh;
      logic [11:0] off_thresh;
      logic [7:0]  options;
      logic        crank_mode;
   } fan_settings_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser;
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [31:0] csr_wdata  = '0;

   item_type         req_item = '0;
   item_type         req_backlog[$];
   logic [15:0]      fan_status_expected[$];
   logic             req_taken = 1'b0;
   state_type        fan_mdl   = '0;
   fan_settings_type settings  = '0;
   logic [31:0]      sim_us    = '0;

   int sender_idle_pct   = 14;
   int receiver_idle_pct = 59;
   int mismatch_count    = 0;
   int beats_checked     = 0;
   int tick_count        = 0;
   int settings_count    = 0;

   string rsp_field[9] = '{"fan_on", "drive_level", "feedback_checked", "drive_error",
                           "force_input_error", "feedback_input_error",
                           "stuck_off_error", "stuck_on_error", "crank_detected"};

   cooling_fan_supervisor uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // command[2:0]
   assign req_tuser = req_item.command;
   // time_now, flag_value, crank_validity, crank_rpm, force_pin_level,
   // force_read_status, feedback_sample, feedback_read_status, drive_write_fault
   assign req_tdata = {5'b0, req_item.drive_write_fault, req_item.feedback_read_status,
                       req_item.feedback_sample, req_item.force_read_status,
                       req_item.force_pin_level, req_item.crank_rpm,
                       req_item.crank_validity, req_item.flag_value, req_item.time_now};

   // one step of the fan logic; returns the status beat packed as on rsp_tdata
   function automatic logic [15:0] advance_fan_model(input item_type it);
      state_type   s;
      logic [31:0] elapsed;
      logic [31:0] settle;
      logic        lvl;
      s = fan_mdl;
      if (settings.options[OPT_ENABLED]) begin
         case (it.command)
            CMD_TICK: begin
               if (s.emergency_state && s.ignition_state) s.fan_state = 1'b1;
               if (s.activate_state) begin
                  if (s.crank_triggered && s.ignition_state) begin
                     s.fan_state        = 1'b1;
                     s.crank_run_accept = 1'b1;
                  end else if (s.crank_run_accept) begin
                     elapsed = it.time_now - s.crank_last_time;
                     if (elapsed >= settings.crank_timeout) begin
                        s.fan_state        = 1'b0;
                        s.crank_run_accept = 1'b0;
                     end else begin
                        s.fan_state = 1'b1;
                     end
                  end
               end
               if (settings.options[OPT_FORCE]) begin
                  if (it.force_read_status == RD_OK) begin
                     lvl = it.force_pin_level ^ settings.options[OPT_FORCE_INV];
                     if (lvl && !s.fan_state && settings.options[OPT_ALLOW_FORCE])
                        s.fan_state = 1'b1;
                  end else if (it.force_read_status != RD_NOT_READY) begin
                     s.diag[DG_FORCE] = 1'b1;
                  end
               end
               if (s.ignition_state && s.crank_seen && s.crank_speed != 0 &&
                   s.crank_speed < settings.min_rpm)
                  s.fan_state = 1'b0;
               if (s.override_engaged) s.fan_state = s.override_value;
               if (s.drive_prev != s.fan_state) begin
                  // a failed write leaves the drive level alone but still restarts the delay
                  if (settings.options[OPT_DRIVE] && it.drive_write_fault)
                     s.diag[DG_DRIVE] = 1'b1;
                  else
                     s.drive_prev = s.fan_state;
                  s.switch_time = it.time_now;
                  s.check_valid = 1'b0;
               end
               settle = s.fan_state ? settings.delay_on : settings.delay_off;
               if (settings.options[OPT_FB]) begin
                  if (!s.check_valid) begin
                     elapsed = it.time_now - s.switch_time;
                     if (elapsed >= settle) s.check_valid = 1'b1;
                  end else begin
                     if (it.feedback_read_status == RD_OK)
                        s.feedback_level = it.feedback_sample;
                     else if (it.feedback_read_status != RD_NOT_READY)
                        s.diag[DG_FB] = 1'b1;
                     if (settings.options[OPT_ANALOG]) begin
                        if (s.fan_state && s.feedback_level < settings.on_thresh)
                           s.diag[DG_STUCKOFF] = 1'b1;
                        else if (!s.fan_state && s.feedback_level > settings.off_thresh)
                           s.diag[DG_STUCKON] = 1'b1;
                     end else begin
                        // digital check always looks at the live sample
                        lvl = (it.feedback_sample != 0) ^ settings.options[OPT_FB_INV];
                        if (s.fan_state && !lvl)
                           s.diag[DG_STUCKOFF] = 1'b1;
                        else if (!s.fan_state && lvl)
                           s.diag[DG_STUCKON] = 1'b1;
                     end
                  end
               end
            end
            CMD_CRANK: begin
               if (it.crank_validity == CRANK_NONE) begin
                  s.crank_triggered = 1'b0;
                  s.crank_seen      = 1'b0;
                  s.crank_speed     = '0;
               end else begin
                  s.crank_seen = 1'b1;
                  if (!settings.crank_mode || it.crank_validity >= CRANK_SYNC)
                     s.crank_triggered = 1'b1;
                  if (s.crank_triggered) s.crank_last_time = it.time_now;
                  s.crank_speed = it.crank_rpm;
               end
            end
            CMD_IGNITION:  s.ignition_state  = it.flag_value;
            CMD_EMERGENCY: s.emergency_state = it.flag_value;
            CMD_ACTIVATE:  s.activate_state  = it.flag_value;
            CMD_FORCE_RESET: begin
               s.override_engaged = 1'b0;
               s.override_value   = 1'b0;
            end
            CMD_FORCE_SET: begin
               s.override_engaged = 1'b1;
               s.override_value   = it.flag_value;
            end
            default: ;
         endcase
      end
      fan_mdl = s;
      return {7'b0, s.crank_seen, s.diag[DG_STUCKON], s.diag[DG_STUCKOFF], s.diag[DG_FB],
              s.diag[DG_FORCE], s.diag[DG_DRIVE], s.check_valid, s.drive_prev, s.fan_state};
   endfunction

   // driver: new beat on the falling edge once the previous one was taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_backlog.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_item   <= req_backlog.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // monitor: compare taken status beats, predict on taken request beats
   always @(posedge clock) begin
      logic [15:0] want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (fan_status_expected.size() == 0) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("%0t: status beat with nothing pending, got %h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = fan_status_expected.pop_front();
               beats_checked++;
               for (int f = 0; f < 9; f++) begin
                  if (rsp_tdata[f] !== want[f]) begin
                     if (mismatch_count < MAX_REPORTS)
                        $display("%0t: %s expected %b actual %b", $time, rsp_field[f],
                                 want[f], rsp_tdata[f]);
                     mismatch_count++;
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            fan_status_expected.push_back(advance_fan_model(req_item));
            if (req_item.command == CMD_TICK) tick_count++;
         end
      end
   end

   task automatic push_beat(input logic [2:0] cmd, input logic [31:0] t, input logic flag,
                            input logic [1:0] validity, input logic [13:0] rpm,
                            input logic pin, input logic [1:0] fst,
                            input logic [11:0] sample, input logic [1:0] bst,
                            input logic fault);
      item_type it;
      it.command              = cmd;
      it.time_now             = t;
      it.flag_value           = flag;
      it.crank_validity       = validity;
      it.crank_rpm            = rpm;
      it.force_pin_level      = pin;
      it.force_read_status    = fst;
      it.feedback_sample      = sample;
      it.feedback_read_status = bst;
      it.drive_write_fault    = fault;
      req_backlog.push_back(it);
   endtask

   // wait until the block is idle with every status beat seen
   task automatic drain_results();
      do @(posedge clock);
      while (req_backlog.size() != 0 || req_tvalid || fan_status_expected.size() != 0);
      repeat (DRAIN_TAIL) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_CRANK_TIMEOUT: settings.crank_timeout = val;
         REG_MIN_RPM:       settings.min_rpm       = val[13:0];
         REG_DELAY_ON:      settings.delay_on      = val;
         REG_DELAY_OFF:     settings.delay_off     = val;
         REG_FB_ON_THRESH:  settings.on_thresh     = val[11:0];
         REG_FB_OFF_THRESH: settings.off_thresh    = val[11:0];
         REG_OPTIONS:       settings.options       = val[7:0];
         REG_CRANK_MODE:    settings.crank_mode    = val[0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input fan_settings_type s);
      csr_write(REG_CRANK_TIMEOUT, s.crank_timeout);
      csr_write(REG_MIN_RPM, 32'(s.min_rpm));
      csr_write(REG_DELAY_ON, s.delay_on);
      csr_write(REG_DELAY_OFF, s.delay_off);
      csr_write(REG_FB_ON_THRESH, 32'(s.on_thresh));
      csr_write(REG_FB_OFF_THRESH, 32'(s.off_thresh));
      csr_write(REG_OPTIONS, 32'(s.options));
      csr_write(REG_CRANK_MODE, 32'(s.crank_mode));
      @(negedge clock);
      csr_we <= 1'b0;
      settings_count++;
   endtask

   function automatic logic [31:0] pick_interval(input int k, input int salt);
      case ((k + salt) % 6)
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         default: return 32'($urandom_range(0, 300));
      endcase
   endfunction

   function automatic logic [11:0] pick_thresh(input int k, input int salt);
      case ((k + salt) % 5)
         0:       return 12'd0;
         1:       return 12'hFFF;
         default: return 12'($urandom_range(0, 400));
      endcase
   endfunction

   function automatic fan_settings_type random_settings(input int k);
      fan_settings_type s;
      s.crank_timeout = pick_interval(k, 0);
      s.delay_on      = pick_interval(k, 2);
      s.delay_off     = pick_interval(k, 4);
      case (k % 5)
         0:       s.min_rpm = 14'd0;
         1:       s.min_rpm = 14'h3FFF;
         default: s.min_rpm = 14'($urandom_range(1, 800));
      endcase
      s.on_thresh  = pick_thresh(k, 0);
      s.off_thresh = pick_thresh(k, 2);
      if (k == 2)
         s.options = 8'hFF;
      else if (k == 6)
         s.options = {1'b0, 7'($urandom)};
      else if (k == 11)
         s.options = 8'h80;
      else
         s.options = {1'b1, 7'($urandom)};
      s.crank_mode = (k < 2) ? k[0] : 1'($urandom_range(1));
      return s;
   endfunction

   function automatic logic [1:0] pick_status();
      int p;
      p = $urandom_range(99);
      if (p < 85) return RD_OK;
      if (p < 92) return RD_NOT_READY;
      if (p < 97) return RD_ERROR;
      return RD_ODD;
   endfunction

   // mostly plausible engine sequences, with unknown commands and odd codes mixed in
   function automatic item_type random_beat();
      item_type it;
      int       p;
      p = $urandom_range(99);
      if (p < 50)      it.command = CMD_TICK;
      else if (p < 66) it.command = CMD_CRANK;
      else if (p < 73) it.command = CMD_IGNITION;
      else if (p < 78) it.command = CMD_EMERGENCY;
      else if (p < 86) it.command = CMD_ACTIVATE;
      else if (p < 91) it.command = CMD_FORCE_RESET;
      else if (p < 96) it.command = CMD_FORCE_SET;
      else if (p < 98) it.command = CMD_UNKNOWN;
      else             it.command = 3'($urandom_range(7));
      if ($urandom_range(99) < 3)
         sim_us = $urandom;
      else
         sim_us = sim_us + 32'($urandom_range(0, 60));
      it.time_now = sim_us;
      case (it.command)
         CMD_IGNITION, CMD_ACTIVATE: it.flag_value = ($urandom_range(99) < 80);
         CMD_EMERGENCY:              it.flag_value = ($urandom_range(99) < 35);
         default:                    it.flag_value = 1'($urandom_range(1));
      endcase
      p = $urandom_range(99);
      if (p < 25)      it.crank_validity = CRANK_NONE;
      else if (p < 60) it.crank_validity = CRANK_DETECTED;
      else if (p < 95) it.crank_validity = CRANK_SYNC;
      else             it.crank_validity = CRANK_ODD;
      p = $urandom_range(99);
      if (p < 50)      it.crank_rpm = 14'($urandom);
      else if (p < 80) it.crank_rpm = 14'($urandom_range(0, 1000));
      else             it.crank_rpm = '0;
      it.force_pin_level   = 1'($urandom_range(1));
      it.force_read_status = pick_status();
      p = $urandom_range(99);
      if (p < 30)      it.feedback_sample = '0;
      else if (p < 70) it.feedback_sample = 12'($urandom);
      else             it.feedback_sample = 12'($urandom_range(0, 500));
      it.feedback_read_status = pick_status();
      it.drive_write_fault    = ($urandom_range(99) < 10);
      return it;
   endfunction

   initial begin
      fan_settings_type s;
      int               n;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // block still disabled out of reset: these change nothing
      push_beat(CMD_IGNITION, 32'd1, 1'b1, CRANK_NONE, 14'd0, 1'b0, RD_OK, 12'd0, RD_OK, 1'b0);
      push_beat(CMD_TICK, 32'd2, 1'b0, CRANK_NONE, 14'd0, 1'b1, RD_OK, 12'd0, RD_OK, 1'b0);
      drain_results();

      s = '{crank_timeout: 32'd100, min_rpm: 14'd500, delay_on: 32'd20, delay_off: 32'd10,
            on_thresh: 12'd2000, off_thresh: 12'd1000, options: 8'hFA, crank_mode: 1'b0};
      apply_settings(s);
      push_beat(CMD_IGNITION, 32'd10, 1'b1, CRANK_NONE, 14'd0, 1'b0, RD_OK, 12'd0, RD_OK, 1'b0);
      push_beat(CMD_EMERGENCY, 32'd11, 1'b1, CRANK_NONE, 14'd0, 1'b0, RD_OK, 12'd0, RD_OK, 1'b0);
      // drive write fails, then the retry goes through
      push_beat(CMD_TICK, 32'd20, 1'b0, CRANK_NONE, 14'd0, 1'b0, RD_OK, 12'd0, RD_OK, 1'b1);
      push_beat(CMD_TICK, 32'd25, 1'b0, CRANK_NONE, 14'd0, 1'b0, RD_OK, 12'd0, RD_OK, 1'b0);
      // settle tick, then the first real check
      push_beat(CMD_TICK, 32'd45, 1'b0, CRANK_NONE, 14'd0, 1'b0, RD_OK, 12'd100, RD_OK, 1'b0);
      push_beat(CMD_TICK, 32'd50, 1'b0, CRANK_NONE, 14'd0, 1'b0, RD_OK, 12'd100, RD_OK, 1'b0);
      // failed feedback read: analog check keeps the stored level
      push_beat(CMD_TICK, 32'd55, 1'b0, CRANK_NONE, 14'd0, 1'b0, RD_OK, 12'hFFF, RD_ERROR, 1'b0);
      push_beat(CMD_EMERGENCY, 32'd56, 1'b0, CRANK_NONE, 14'd0, 1'b0, RD_OK, 12'd0, RD_OK, 1'b0);
      push_beat(CMD_ACTIVATE, 32'd57, 1'b1, CRANK_NONE, 14'd0, 1'b0, RD_OK, 12'd0, RD_OK, 1'b0);
      push_beat(CMD_CRANK, 32'd60, 1'b0, CRANK_DETECTED, 14'h3FFF, 1'b0, RD_OK, 12'd0, RD_OK,
                1'b0);
      push_beat(CMD_TICK, 32'd61, 1'b0, CRANK_NONE, 14'd0, 1'b0, RD_OK, 12'd3000, RD_OK, 1'b0);
      push_beat(CMD_CRANK, 32'd62, 1'b0, CRANK_NONE, 14'd0, 1'b0, RD_OK, 12'd0, RD_OK, 1'b0);
      // run-on expired; force read with an out-of-range status
      push_beat(CMD_TICK, 32'd200, 1'b0, CRANK_NONE, 14'd0, 1'b0, RD_ODD, 12'd0, RD_OK, 1'b0);
      push_beat(CMD_CRANK, 32'd210, 1'b0, CRANK_ODD, 14'd100, 1'b0, RD_OK, 12'd0, RD_OK, 1'b0);
      // low rpm cutoff wins over crank activity
      push_beat(CMD_TICK, 32'd211, 1'b0, CRANK_NONE, 14'd0, 1'b0, RD_OK, 12'd0, RD_OK, 1'b0);
      push_beat(CMD_FORCE_SET, 32'd212, 1'b1, CRANK_NONE, 14'd0, 1'b0, RD_OK, 12'd0, RD_OK, 1'b0);
      push_beat(CMD_TICK, 32'd213, 1'b0, CRANK_NONE, 14'd0, 1'b0, RD_OK, 12'hFFF, RD_OK, 1'b0);
      push_beat(CMD_FORCE_RESET, 32'd214, 1'b1, CRANK_SYNC, 14'd0, 1'b1, RD_OK, 12'd0, RD_OK,
                1'b0);
      push_beat(CMD_UNKNOWN, 32'hFFFF_FFFF, 1'b1, CRANK_ODD, 14'h3FFF, 1'b1, RD_ODD, 12'hFFF,
                RD_ODD, 1'b1);
      push_beat(CMD_TICK, 32'hFFFF_FFFF, 1'b0, CRANK_NONE, 14'd0, 1'b1, RD_OK, 12'hFFF, RD_OK,
                1'b0);
      // time counter wraps
      push_beat(CMD_TICK, 32'd5, 1'b0, CRANK_NONE, 14'd0, 1'b1, RD_OK, 12'd0, RD_OK, 1'b0);
      drain_results();

      s = '{crank_timeout: 32'd50, min_rpm: 14'd0, delay_on: 32'd0, delay_off: 32'd0,
            on_thresh: 12'd0, off_thresh: 12'd0, options: 8'hB5, crank_mode: 1'b1};
      apply_settings(s);
      // synchronized mode: detected alone must not trigger
      push_beat(CMD_CRANK, 32'd300, 1'b0, CRANK_DETECTED, 14'd900, 1'b0, RD_OK, 12'd0, RD_OK,
                1'b0);
      push_beat(CMD_TICK, 32'd301, 1'b0, CRANK_NONE, 14'd0, 1'b0, RD_OK, 12'd0, RD_OK, 1'b0);
      push_beat(CMD_CRANK, 32'd302, 1'b0, CRANK_SYNC, 14'd900, 1'b0, RD_OK, 12'd0, RD_OK, 1'b0);
      push_beat(CMD_TICK, 32'd303, 1'b0, CRANK_NONE, 14'd0, 1'b0, RD_OK, 12'd1, RD_NOT_READY,
                1'b0);
      drain_results();

      for (int k = 0; k < 14; k++) begin
         if (k == 5) begin
            sender_idle_pct   = 59;
            receiver_idle_pct = 14;
         end else if (k == 10) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         apply_settings(random_settings(k));
         if (k % 4 == 0) sim_us = 32'hFFFF_FF00 + 32'($urandom_range(0, 200));
         n = (k == 6) ? 40 : 105;
         repeat (n) req_backlog.push_back(random_beat());
         drain_results();
      end

      $display("checked %0d status beats (%0d ticks) over %0d register settings",
               beats_checked, tick_count, settings_count);
      $display("%0d field mismatches seen", mismatch_count);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d status beats still pending", fan_status_expected.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: files.f
hdl/cfs_pkg.sv
hdl/cooling_fan_supervisor.sv
tb/tb_cooling_fan_supervisor.sv
